/* rtl/uhc_pkg.sv */
// uhc_pkg: constants, field offsets and the octal field parser for the tar header checker
// no dependencies; imported by ustar_header_check

package uhc_pkg;

    localparam int BLOCK_BYTES        = 512;
    localparam int NAME_FIELD_BYTES   = 100;
    localparam int PREFIX_FIELD_BYTES = 155;
    localparam int POS_W              = $clog2(BLOCK_BYTES);
    localparam int NAME_AW            = $clog2(NAME_FIELD_BYTES);
    localparam int PREFIX_AW          = $clog2(PREFIX_FIELD_BYTES);
    localparam int SIZE_W             = 36;
    localparam int CHK_W              = 24;
    localparam int SUM_W              = 17;
    localparam int LEN_W              = 9;

    localparam logic [POS_W-1:0] OFS_SIZE   = POS_W'(124);
    localparam logic [POS_W-1:0] LEN_SIZE   = POS_W'(12);
    localparam logic [POS_W-1:0] OFS_CHK    = POS_W'(148);
    localparam logic [POS_W-1:0] LEN_CHK    = POS_W'(8);
    localparam logic [POS_W-1:0] OFS_TYPE   = POS_W'(156);
    localparam logic [POS_W-1:0] OFS_MAGIC  = POS_W'(257);
    localparam logic [POS_W-1:0] LEN_MAGIC  = POS_W'(5);
    localparam logic [POS_W-1:0] OFS_PREFIX = POS_W'(345);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(BLOCK_BYTES - 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_CHAR    = 1'b1;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_TRAIL
    } oct_phase_t;

    typedef struct packed {
        logic [SIZE_W-1:0] value;
        oct_phase_t        phase;
        logic              digit;
        logic              error;
    } oct_state_t;

    typedef enum logic [1:0] {
        CH_ZERO,
        CH_SLASH,
        CH_PREFIX,
        CH_NAME
    } char_sel_t;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // strict octal: padding, digits, padding only
    function automatic oct_state_t oct_feed(input oct_state_t cur, input logic [7:0] b);
        oct_state_t        nxt;
        logic              pad;
        logic              dig;
        logic [SIZE_W-1:0] d;
        nxt = cur;
        pad = (b == CHAR_SPACE) || (b == 8'h00);
        dig = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
        d   = {{(SIZE_W-3){1'b0}}, b[2:0]};
        case (cur.phase)
            PH_LEAD: begin
                if (!pad) begin
                    if (dig) begin
                        nxt.value = d;
                        nxt.digit = 1'b1;
                        nxt.phase = PH_DIGITS;
                    end else begin
                        nxt.error = 1'b1;
                        nxt.phase = PH_TRAIL;
                    end
                end
            end
            PH_DIGITS: begin
                if (pad) begin
                    nxt.phase = PH_TRAIL;
                end else if (dig) begin
                    nxt.value = {cur.value[SIZE_W-4:0], 3'b000} + d;
                end else begin
                    nxt.error = 1'b1;
                    nxt.phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (!pad) nxt.error = 1'b1;
            end
            default: nxt = cur;
        endcase
        return nxt;
    endfunction

endpackage

/* rtl/ustar_header_check.sv */
// ustar_header_check: streaming check of one 512-byte tar header, name field stores
// depends on uhc_pkg (offsets, octal parser, select codes)
//
//  channel   dir  group   payload
//  s_axis    in   tdata   data_byte, name_index       tuser  mode
//  m_axis    out  tdata   status .. name_char         tuser  kind
//
// one transfer in per cycle while s_axis_tready is high; header bytes with no result update state and free the slot
// a result passes the read stage (memory read), then the output register, before it leaves m_axis
// reset clears control state; the name and prefix stores are not cleared
// s_axis_tready drops only while a result waits in both the read stage and the output register
// name stores are single memories: written by header bytes, read by name reads

module ustar_header_check
    import uhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], name_index[15:8]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // status, is_zero, member_size[37:2], type_flag[45:38],
                                        // name_length[54:46], name_char[62:55], zero pad
    output logic        m_axis_tuser    // kind
);

    logic [7:0] name_mem [NAME_FIELD_BYTES];
    logic [7:0] prefix_mem [PREFIX_FIELD_BYTES];

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 zero_reg, zero_next;
    logic [CHK_W-1:0]     chk_value_reg, chk_value_next;
    oct_phase_t           chk_phase_reg, chk_phase_next;
    logic                 chk_digit_reg, chk_digit_next;
    logic                 chk_err_reg, chk_err_next;
    oct_state_t           size_reg, size_next;
    logic                 mg_present_reg, mg_present_next;
    logic                 mg_mismatch_reg, mg_mismatch_next;
    logic [NAME_AW-1:0]   name_count_reg, name_count_next;
    logic                 name_ended_reg, name_ended_next;
    logic [PREFIX_AW-1:0] prefix_count_reg, prefix_count_next;
    logic                 prefix_ended_reg, prefix_ended_next;
    logic [7:0]           type_reg, type_next;
    logic [NAME_AW-1:0]   lat_name_reg, lat_name_next;
    logic [PREFIX_AW-1:0] lat_prefix_reg, lat_prefix_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_kind_reg;
    logic                 s1_status_reg;
    logic                 s1_zero_reg;
    logic [SIZE_W-1:0]    s1_size_reg;
    logic [7:0]           s1_type_reg;
    logic [LEN_W-1:0]     s1_len_reg;
    char_sel_t            s1_sel_reg;
    logic [7:0]           name_rd_reg;
    logic [7:0]           prefix_rd_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [63:0]          m_data_reg;
    logic                 m_kind_reg;

    logic                 accept, s1_adv, is_byte, is_last;
    logic [7:0]           b;
    logic [7:0]           idx;
    logic                 in_chk, in_size, in_name, in_prefix, in_magic;
    logic [POS_W-1:0]     magic_ofs;
    logic [POS_W-1:0]     prefix_ofs;
    oct_state_t           chk_cur, chk_fed, size_fed;
    logic                 bad;
    logic [PREFIX_AW-1:0] pl_eff;
    logic [LEN_W-1:0]     verdict_len;
    logic [LEN_W-1:0]     base, off;
    char_sel_t            sel;
    logic [7:0]           s1_char;
    logic                 name_we, prefix_we, name_re, prefix_re;

    assign b      = s_axis_tdata[7:0];
    assign idx    = s_axis_tdata[15:8];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign is_byte = (s_axis_tuser == MODE_BYTE);
    assign is_last = is_byte && (pos_reg == LAST_POS);
    assign s1_adv = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !m_valid_reg || m_axis_tready;

    assign in_chk    = (pos_reg >= OFS_CHK) && (pos_reg < OFS_CHK + LEN_CHK);
    assign in_size   = (pos_reg >= OFS_SIZE) && (pos_reg < OFS_SIZE + LEN_SIZE);
    assign in_name   = (pos_reg < POS_W'(NAME_FIELD_BYTES));
    assign in_magic  = (pos_reg >= OFS_MAGIC) && (pos_reg < OFS_MAGIC + LEN_MAGIC);
    assign in_prefix = (pos_reg >= OFS_PREFIX)
                    && (pos_reg < OFS_PREFIX + POS_W'(PREFIX_FIELD_BYTES));
    assign magic_ofs  = pos_reg - OFS_MAGIC;
    assign prefix_ofs = pos_reg - OFS_PREFIX;

    assign chk_cur  = '{value: {{(SIZE_W-CHK_W){1'b0}}, chk_value_reg}, phase: chk_phase_reg,
                        digit: chk_digit_reg, error: chk_err_reg};
    assign chk_fed  = oct_feed(chk_cur, b);
    assign size_fed = oct_feed(size_reg, b);

    // per-byte state update and verdict
    always_comb begin
        pos_next          = pos_reg;
        sum_next          = sum_reg;
        zero_next         = zero_reg;
        chk_value_next    = chk_value_reg;
        chk_phase_next    = chk_phase_reg;
        chk_digit_next    = chk_digit_reg;
        chk_err_next      = chk_err_reg;
        size_next         = size_reg;
        mg_present_next   = mg_present_reg;
        mg_mismatch_next  = mg_mismatch_reg;
        name_count_next   = name_count_reg;
        name_ended_next   = name_ended_reg;
        prefix_count_next = prefix_count_reg;
        prefix_ended_next = prefix_ended_reg;
        type_next         = type_reg;
        lat_name_next     = lat_name_reg;
        lat_prefix_next   = lat_prefix_reg;

        sum_next  = sum_reg + (in_chk ? {{(SUM_W-8){1'b0}}, CHAR_SPACE}
                                      : {{(SUM_W-8){1'b0}}, b});
        zero_next = zero_reg && (b == 8'h00);
        if (in_name && !name_ended_reg) begin
            if (b == 8'h00) name_ended_next = 1'b1;
            else name_count_next = name_count_reg + NAME_AW'(1);
        end
        if (in_size) size_next = size_fed;
        if (in_chk) begin
            chk_value_next = chk_fed.value[CHK_W-1:0];
            chk_phase_next = chk_fed.phase;
            chk_digit_next = chk_fed.digit;
            chk_err_next   = chk_fed.error;
        end
        if (pos_reg == OFS_TYPE) type_next = b;
        if (in_magic) begin
            if (pos_reg == OFS_MAGIC && b != 8'h00) mg_present_next = 1'b1;
            if (b != magic_char(magic_ofs[2:0])) mg_mismatch_next = 1'b1;
        end
        if (in_prefix && !prefix_ended_reg) begin
            if (b == 8'h00) prefix_ended_next = 1'b1;
            else prefix_count_next = prefix_count_reg + PREFIX_AW'(1);
        end
        pos_next = pos_reg + POS_W'(1);

        bad = chk_err_reg || !chk_digit_reg
           || (chk_value_reg != {{(CHK_W-SUM_W){1'b0}}, sum_next})
           || size_reg.error || !size_reg.digit
           || (mg_present_reg && mg_mismatch_reg)
           || (name_count_reg == '0);
        pl_eff = mg_present_reg ? prefix_count_reg : '0;
        verdict_len = (pl_eff != '0)
                    ? LEN_W'(pl_eff) + LEN_W'(1) + LEN_W'(name_count_reg)
                    : LEN_W'(name_count_reg);

        if (is_last) begin
            pos_next          = '0;
            sum_next          = '0;
            zero_next         = 1'b1;
            chk_value_next    = '0;
            chk_phase_next    = PH_LEAD;
            chk_digit_next    = 1'b0;
            chk_err_next      = 1'b0;
            size_next         = '{value: '0, phase: PH_LEAD, digit: 1'b0, error: 1'b0};
            mg_present_next   = 1'b0;
            mg_mismatch_next  = 1'b0;
            name_count_next   = '0;
            name_ended_next   = 1'b0;
            prefix_count_next = '0;
            prefix_ended_next = 1'b0;
            type_next         = '0;
            if (zero_reg && b == 8'h00 || bad) begin
                lat_name_next   = '0;
                lat_prefix_next = '0;
            end else begin
                lat_name_next   = name_count_reg;
                lat_prefix_next = pl_eff;
            end
        end
    end

    // name read select: prefix, slash, name, else zero
    always_comb begin
        base = (lat_prefix_reg != '0) ? LEN_W'(lat_prefix_reg) + LEN_W'(1) : '0;
        off  = {1'b0, idx} - base;
        if ({1'b0, idx} < LEN_W'(lat_prefix_reg)) begin
            sel = CH_PREFIX;
        end else if (lat_prefix_reg != '0 && {1'b0, idx} == LEN_W'(lat_prefix_reg)) begin
            sel = CH_SLASH;
        end else if ({1'b0, idx} >= base && off < LEN_W'(lat_name_reg)) begin
            sel = CH_NAME;
        end else begin
            sel = CH_ZERO;
        end
    end

    assign name_we   = accept && is_byte && in_name;
    assign prefix_we = accept && is_byte && in_prefix;
    assign name_re   = accept && !is_byte && (sel == CH_NAME);
    assign prefix_re = accept && !is_byte && (sel == CH_PREFIX);

    always_ff @(posedge aclk) begin
        if (name_we) name_mem[pos_reg[NAME_AW-1:0]] <= b;
        if (name_re) name_rd_reg <= name_mem[off[NAME_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (prefix_we) prefix_mem[prefix_ofs[PREFIX_AW-1:0]] <= b;
        if (prefix_re) prefix_rd_reg <= prefix_mem[idx[PREFIX_AW-1:0]];
    end

    always_comb begin
        case (s1_sel_reg)
            CH_PREFIX: s1_char = prefix_rd_reg;
            CH_NAME:   s1_char = name_rd_reg;
            CH_SLASH:  s1_char = CHAR_SLASH;
            default:   s1_char = 8'h00;
        endcase
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept && (!is_byte || is_last)) s1_valid_next = 1'b1;
        else if (s1_adv) s1_valid_next = 1'b0;
        m_valid_next = m_valid_reg;
        if (s1_adv) m_valid_next = 1'b1;
        else if (m_axis_tready) m_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg          <= '0;
            sum_reg          <= '0;
            zero_reg         <= 1'b1;
            chk_value_reg    <= '0;
            chk_phase_reg    <= PH_LEAD;
            chk_digit_reg    <= 1'b0;
            chk_err_reg      <= 1'b0;
            size_reg         <= '{value: '0, phase: PH_LEAD, digit: 1'b0, error: 1'b0};
            mg_present_reg   <= 1'b0;
            mg_mismatch_reg  <= 1'b0;
            name_count_reg   <= '0;
            name_ended_reg   <= 1'b0;
            prefix_count_reg <= '0;
            prefix_ended_reg <= 1'b0;
            type_reg         <= '0;
            lat_name_reg     <= '0;
            lat_prefix_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept && is_byte) begin
                pos_reg          <= pos_next;
                sum_reg          <= sum_next;
                zero_reg         <= zero_next;
                chk_value_reg    <= chk_value_next;
                chk_phase_reg    <= chk_phase_next;
                chk_digit_reg    <= chk_digit_next;
                chk_err_reg      <= chk_err_next;
                size_reg         <= size_next;
                mg_present_reg   <= mg_present_next;
                mg_mismatch_reg  <= mg_mismatch_next;
                name_count_reg   <= name_count_next;
                name_ended_reg   <= name_ended_next;
                prefix_count_reg <= prefix_count_next;
                prefix_ended_reg <= prefix_ended_next;
                type_reg         <= type_next;
                lat_name_reg     <= lat_name_next;
                lat_prefix_reg   <= lat_prefix_next;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!is_byte) begin
                s1_kind_reg   <= KIND_CHAR;
                s1_status_reg <= 1'b0;
                s1_zero_reg   <= 1'b0;
                s1_size_reg   <= '0;
                s1_type_reg   <= '0;
                s1_len_reg    <= '0;
                s1_sel_reg    <= sel;
            end else if (is_last) begin
                s1_kind_reg <= KIND_VERDICT;
                s1_sel_reg  <= CH_ZERO;
                if (zero_reg && b == 8'h00) begin
                    s1_status_reg <= 1'b0;
                    s1_zero_reg   <= 1'b1;
                    s1_size_reg   <= '0;
                    s1_type_reg   <= '0;
                    s1_len_reg    <= '0;
                end else if (bad) begin
                    s1_status_reg <= 1'b1;
                    s1_zero_reg   <= 1'b0;
                    s1_size_reg   <= '0;
                    s1_type_reg   <= '0;
                    s1_len_reg    <= '0;
                end else begin
                    s1_status_reg <= 1'b0;
                    s1_zero_reg   <= 1'b0;
                    s1_size_reg   <= size_reg.value;
                    s1_type_reg   <= type_reg;
                    s1_len_reg    <= verdict_len;
                end
            end
        end
        if (s1_adv) begin
            m_kind_reg <= s1_kind_reg;
            m_data_reg <= {1'b0, s1_char, s1_len_reg, s1_type_reg, s1_size_reg,
                           s1_zero_reg, s1_status_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;

    a_pos_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_last |=> s1_valid_reg && pos_reg == '0 && zero_reg)
        else $error("block position did not wrap after the last header byte");

    a_latched_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        lat_prefix_reg != '0 |-> lat_name_reg != '0)
        else $error("latched prefix length without a name");

    a_count_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        name_count_reg <= NAME_AW'(NAME_FIELD_BYTES)
        && prefix_count_reg <= PREFIX_AW'(PREFIX_FIELD_BYTES))
        else $error("field length count beyond field size");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == KIND_VERDICT && m_data_reg[0]
        |-> m_data_reg[54:2] == '0)
        else $error("error verdict carries non-zero fields");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_sel_reg))
        else $error("read stage lost a waiting result");

endmodule
